FILE: rtl/ite_pkg.sv
// Package: shared types, constants and tables of the timestamp to epoch converter.
`timescale 1ns / 1ps
package ite_pkg;

   // ASCII codes used by the parser
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_NINE  = 8'h39;
   localparam logic [7:0] ASCII_DASH  = 8'h2D;
   localparam logic [7:0] ASCII_PLUS  = 8'h2B;
   localparam logic [7:0] ASCII_COLON = 8'h3A;
   localparam logic [7:0] ASCII_T     = 8'h54;

   // character positions
   localparam logic [4:0] POS_SEC_FIRST = 5'd17;
   localparam logic [4:0] POS_SEC_LAST  = 5'd22;
   localparam logic [4:0] POS_MIN_LAST  = 5'd18;
   localparam logic [4:0] POS_OFF_FIRST = 5'd19;
   localparam logic [4:0] POS_MAX       = 5'd31;

   // offset sequencing: sign, hh, separator, mm
   localparam logic [2:0] OFF_STEP_SIGN = 3'd1;
   localparam logic [2:0] OFF_STEP_DONE = 3'd6;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // calendar arithmetic constants
   localparam logic [14:0] YEAR_BIAS    = 15'd400;      // keeps year positive for floors
   localparam logic [23:0] DAYS_BIAS    = 24'd865566;   // 719468 + 146097 + 1
   localparam logic [14:0] RECIP_12     = 15'd171;      // floor(x*171 >> 11) = x/12, x < 128
   localparam logic [12:0] RECIP_100    = 13'd5243;     // floor(y*5243 >> 19) = y/100
   localparam int          SEC_PER_DAY  = 86400;
   localparam int          SEC_PER_HOUR = 3600;
   localparam int          SEC_PER_MIN  = 60;

   typedef struct packed {
      logic [13:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [19:0] second;
      logic        apply_off;
      logic        off_neg;
      logic [6:0]  off_hours;
      logic [6:0]  off_minutes;
      logic        fault;
   } ite_rec_type;

   // day of a March-based year at which month index mon (0 = January) begins
   function automatic logic [8:0] month_start_day(input logic [3:0] mon);
      logic [8:0] r;
      unique case (mon)
         4'd0:    r = 9'd306;
         4'd1:    r = 9'd337;
         4'd2:    r = 9'd0;
         4'd3:    r = 9'd31;
         4'd4:    r = 9'd61;
         4'd5:    r = 9'd92;
         4'd6:    r = 9'd122;
         4'd7:    r = 9'd153;
         4'd8:    r = 9'd184;
         4'd9:    r = 9'd214;
         4'd10:   r = 9'd245;
         4'd11:   r = 9'd275;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/ite_req_if.sv
// Interfaces: character request channel and epoch response channel.
`timescale 1ns / 1ps
interface ite_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface ite_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [38:0] unix_secs;
   logic               format_error;

   modport source (output valid, output unix_secs, output format_error, input ready);
   modport sink   (input valid, input unix_secs, input format_error, output ready);
endinterface

FILE: rtl/ite_front.sv
// Front end: per-character parser that gathers the fields and checks the format.
`timescale 1ns / 1ps
module ite_front (
   input  logic              clock,
   input  logic              reset,
   ite_req_if.sink           req_chan,
   input  logic              convert_utc,
   input  logic              queue_full,
   output logic              rec_push,
   output ite_pkg::ite_rec_type rec_out
);

   logic [4:0]  pos_ff, pos_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  month_ff, month_in;
   logic [6:0]  day_ff, day_in;
   logic [6:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [19:0] second_ff, second_in;
   logic        sec_closed_ff, sec_closed_in;
   logic        fault_ff, fault_in;
   logic        off_found_ff, off_found_in;
   logic        off_neg_ff, off_neg_in;
   logic [2:0]  off_step_ff, off_step_in;
   logic [6:0]  off_hours_ff, off_hours_in;
   logic [6:0]  off_minutes_ff, off_minutes_in;
   logic        off_bad_ff, off_bad_in;

   logic       accept;
   logic [7:0] c;
   logic       dig;
   logic [3:0] d;
   logic       apply;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;
   assign c              = req_chan.char_code;
   assign dig            = (c >= ite_pkg::ASCII_ZERO) && (c <= ite_pkg::ASCII_NINE);
   assign d              = dig ? c[3:0] : 4'd0;

   always_comb begin
      year_in        = year_ff;
      month_in       = month_ff;
      day_in         = day_ff;
      hour_in        = hour_ff;
      minute_in      = minute_ff;
      second_in      = second_ff;
      sec_closed_in  = sec_closed_ff;
      fault_in       = fault_ff;
      off_found_in   = off_found_ff;
      off_neg_in     = off_neg_ff;
      off_step_in    = off_step_ff;
      off_hours_in   = off_hours_ff;
      off_minutes_in = off_minutes_ff;
      off_bad_in     = off_bad_ff;

      unique case (pos_ff)
         5'd0, 5'd1, 5'd2, 5'd3: begin
            year_in = 14'(year_ff * 14'd10 + 14'(d));
            if (!dig) fault_in = 1'b1;
         end
         5'd5, 5'd6: begin
            month_in = 7'(month_ff * 7'd10 + 7'(d));
            if (!dig) fault_in = 1'b1;
         end
         5'd8, 5'd9: begin
            day_in = 7'(day_ff * 7'd10 + 7'(d));
            if (!dig) fault_in = 1'b1;
         end
         5'd11, 5'd12: begin
            hour_in = 7'(hour_ff * 7'd10 + 7'(d));
            if (!dig) fault_in = 1'b1;
         end
         5'd14, 5'd15: begin
            minute_in = 7'(minute_ff * 7'd10 + 7'(d));
            if (!dig) fault_in = 1'b1;
         end
         5'd4, 5'd7: begin
            if (c != ite_pkg::ASCII_DASH) fault_in = 1'b1;
         end
         5'd10: begin
            if (c != ite_pkg::ASCII_T) fault_in = 1'b1;
         end
         5'd13, 5'd16: begin
            if (c != ite_pkg::ASCII_COLON) fault_in = 1'b1;
         end
         default: begin
         end
      endcase

      // integer seconds: leading digits only
      if (pos_ff >= ite_pkg::POS_SEC_FIRST && pos_ff <= ite_pkg::POS_SEC_LAST
          && !sec_closed_ff) begin
         if (dig) second_in = 20'(second_ff * 20'd10 + 20'(d));
         else     sec_closed_in = 1'b1;
      end

      // first sign from position 19 opens the offset; step 3 is the unchecked separator
      if (pos_ff >= ite_pkg::POS_OFF_FIRST) begin
         if (!off_found_ff) begin
            if (c == ite_pkg::ASCII_PLUS || c == ite_pkg::ASCII_DASH) begin
               off_found_in = 1'b1;
               off_neg_in   = (c == ite_pkg::ASCII_DASH);
               off_step_in  = ite_pkg::OFF_STEP_SIGN;
            end
         end else if (off_step_ff >= 3'd1 && off_step_ff <= 3'd5) begin
            if (off_step_ff == 3'd1 || off_step_ff == 3'd2) begin
               off_hours_in = 7'(off_hours_ff * 7'd10 + 7'(d));
               if (!dig) off_bad_in = 1'b1;
            end else if (off_step_ff == 3'd4 || off_step_ff == 3'd5) begin
               off_minutes_in = 7'(off_minutes_ff * 7'd10 + 7'(d));
               if (!dig) off_bad_in = 1'b1;
            end
            off_step_in = 3'(off_step_ff + 3'd1);
         end
      end

      pos_in = (pos_ff < ite_pkg::POS_MAX) ? 5'(pos_ff + 5'd1) : pos_ff;
   end

   assign apply = convert_utc && off_found_in;

   always_comb begin
      rec_out.year        = year_in;
      rec_out.month       = month_in;
      rec_out.day         = day_in;
      rec_out.hour        = hour_in;
      rec_out.minute      = minute_in;
      rec_out.second      = second_in;
      rec_out.apply_off   = apply;
      rec_out.off_neg     = off_neg_in;
      rec_out.off_hours   = off_hours_in;
      rec_out.off_minutes = off_minutes_in;
      rec_out.fault       = fault_in || (pos_ff < ite_pkg::POS_MIN_LAST)
                            || (apply && (off_bad_in || off_step_in != ite_pkg::OFF_STEP_DONE));
   end

   assign rec_push = accept && req_chan.last_char;

   always_ff @(posedge clock) begin
      if (reset || rec_push) begin
         pos_ff         <= '0;
         year_ff        <= '0;
         month_ff       <= '0;
         day_ff         <= '0;
         hour_ff        <= '0;
         minute_ff      <= '0;
         second_ff      <= '0;
         sec_closed_ff  <= 1'b0;
         fault_ff       <= 1'b0;
         off_found_ff   <= 1'b0;
         off_neg_ff     <= 1'b0;
         off_step_ff    <= '0;
         off_hours_ff   <= '0;
         off_minutes_ff <= '0;
         off_bad_ff     <= 1'b0;
      end else if (accept) begin
         pos_ff         <= pos_in;
         year_ff        <= year_in;
         month_ff       <= month_in;
         day_ff         <= day_in;
         hour_ff        <= hour_in;
         minute_ff      <= minute_in;
         second_ff      <= second_in;
         sec_closed_ff  <= sec_closed_in;
         fault_ff       <= fault_in;
         off_found_ff   <= off_found_in;
         off_neg_ff     <= off_neg_in;
         off_step_ff    <= off_step_in;
         off_hours_ff   <= off_hours_in;
         off_minutes_ff <= off_minutes_in;
         off_bad_ff     <= off_bad_in;
      end
   end

endmodule

FILE: rtl/ite_queue.sv
// Short queue of parsed timestamp records between the parser and the calculator.
`timescale 1ns / 1ps
module ite_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ite_pkg::ite_rec_type push_rec,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output ite_pkg::ite_rec_type head_rec
);

   ite_pkg::ite_rec_type        mem_ff [ite_pkg::QUEUE_DEPTH];
   logic [ite_pkg::QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [ite_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic                         do_push, do_pop;

   assign full      = (count_ff == (ite_pkg::QUEUE_AW+1)'(ite_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_rec  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop)      count_in = (ite_pkg::QUEUE_AW+1)'(count_ff + 1'b1);
      else if (do_pop && !do_push) count_in = (ite_pkg::QUEUE_AW+1)'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= ite_pkg::QUEUE_AW'(wr_ptr_ff + 1'b1);
         if (do_pop)  rd_ptr_ff <= ite_pkg::QUEUE_AW'(rd_ptr_ff + 1'b1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_rec;
   end

endmodule

FILE: rtl/ite_back.sv
// Back end: four-stage pipeline that turns a parsed record into Unix seconds.
`timescale 1ns / 1ps
module ite_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rec_valid,
   input  ite_pkg::ite_rec_type rec_in,
   output logic                 rec_pop,
   ite_rsp_if.source            rsp_chan
);

   logic advance;

   // stage 1: month normalisation, time of day and offset
   logic [6:0]  mx;
   logic [3:0]  mq_raw, mq, mon_raw, mon;
   logic [1:0]  ydec;
   logic [22:0] hms, off;
   logic [22:0] adj_in;
   logic [13:0] y1_in;
   logic [9:0]  dd1_in;

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic        e1_ff, e2_ff, e3_ff;
   logic [13:0] y1_ff;
   logic [9:0]  dd1_ff, dd2_ff;
   logic signed [22:0] adj1_ff, adj2_ff, adj3_ff;

   // stage 2: year products
   logic [26:0] yp100;
   logic [21:0] y365_in;
   logic [21:0] y365_ff;
   logic [11:0] y4_ff;
   logic [6:0]  q100_ff;

   // stage 3: day count
   logic signed [23:0] days_in, days_ff;

   // stage 4: seconds
   logic signed [40:0] secs;
   logic signed [38:0] epoch_ff;
   logic               err_ff;

   assign advance  = !v4_ff || rsp_chan.ready;
   assign rec_pop  = advance;

   always_comb begin
      mx      = 7'(rec_in.month - 7'd1);
      mq_raw  = 4'((15'(mx) * ite_pkg::RECIP_12) >> 11);
      mon_raw = 4'(mx - 7'(mq_raw) * 7'd12);
      if (rec_in.month == 7'd0) begin
         mq  = 4'd0;
         mon = 4'd11;
      end else begin
         mq  = mq_raw;
         mon = mon_raw;
      end
      // January and February belong to the previous March-based year
      ydec  = 2'((rec_in.month == 7'd0) ? 1 : 0) + 2'((mon <= 4'd1) ? 1 : 0);
      y1_in = 14'(15'(rec_in.year) + ite_pkg::YEAR_BIAS + 15'(mq) - 15'(ydec));
      dd1_in = 10'(ite_pkg::month_start_day(mon)) + 10'(rec_in.day);

      hms = 23'(rec_in.hour) * 23'(ite_pkg::SEC_PER_HOUR)
          + 23'(rec_in.minute) * 23'(ite_pkg::SEC_PER_MIN)
          + 23'(rec_in.second);
      off = 23'(rec_in.off_hours) * 23'(ite_pkg::SEC_PER_HOUR)
          + 23'(rec_in.off_minutes) * 23'(ite_pkg::SEC_PER_MIN);
      // a '+' offset is subtracted, a '-' offset added
      if (!rec_in.apply_off)   adj_in = hms;
      else if (rec_in.off_neg) adj_in = 23'(hms + off);
      else                     adj_in = 23'(hms - off);
   end

   always_comb begin
      yp100   = 27'(y1_ff) * 27'(ite_pkg::RECIP_100);
      y365_in = 22'(22'(y1_ff) * 22'd365);
   end

   always_comb begin
      days_in = 24'(y365_ff) + 24'(y4_ff) - 24'(q100_ff) + 24'(q100_ff >> 2)
              + 24'(dd2_ff) - ite_pkg::DAYS_BIAS;
   end

   assign secs = 41'(days_ff) * 41'(ite_pkg::SEC_PER_DAY) + 41'(adj3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= rec_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e1_ff   <= rec_in.fault;
         y1_ff   <= y1_in;
         dd1_ff  <= dd1_in;
         adj1_ff <= adj_in;

         e2_ff   <= e1_ff;
         y365_ff <= y365_in;
         y4_ff   <= y1_ff[13:2];
         q100_ff <= yp100[25:19];
         dd2_ff  <= dd1_ff;
         adj2_ff <= adj1_ff;

         e3_ff   <= e2_ff;
         days_ff <= days_in;
         adj3_ff <= adj2_ff;

         err_ff   <= e3_ff;
         epoch_ff <= e3_ff ? '0 : secs[38:0];
      end
   end

   assign rsp_chan.valid         = v4_ff;
   assign rsp_chan.unix_secs     = epoch_ff;
   assign rsp_chan.format_error  = err_ff;

endmodule

FILE: rtl/iso8601_timestamp_to_epoch_top.sv
// Top level: ISO 8601 timestamp text to Unix seconds converter.
//
//   channel  direction  transfer                     payload
//   req_     in         one character per transfer   char_code[7:0], last_char
//   rsp_     out        one result per string        unix_secs[38:0] signed, format_error
//   csr_     in         write on csr_wr_en           convert_utc (bit 0 of csr_wr_data)
//
// One character is taken per cycle while the record queue is not full.
// Each parsed record is written into the four-entry record queue and then passes through
// the calculator pipeline to its output register.
// The parser stalls only when that queue is full; the calculator pipeline stalls only
// while its output register holds a result not yet taken.
// Synchronous reset clears parser state, queue and pipeline; convert_utc resets to 1.
`timescale 1ns / 1ps
module iso8601_timestamp_to_epoch_top (
   input  logic       clock,
   input  logic       reset,
   ite_req_if.sink    req_chan,
   ite_rsp_if.source  rsp_chan,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic                 convert_utc_ff;
   logic                 rec_push, queue_full, queue_pop, queue_not_empty;
   ite_pkg::ite_rec_type push_rec, head_rec;

   always_ff @(posedge clock) begin
      if (reset)          convert_utc_ff <= 1'b1;
      else if (csr_wr_en) convert_utc_ff <= csr_wr_data;
   end

   ite_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .convert_utc (convert_utc_ff),
      .queue_full  (queue_full),
      .rec_push    (rec_push),
      .rec_out     (push_rec)
   );

   ite_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_rec  (push_rec),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head_rec  (head_rec)
   );

   ite_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (queue_not_empty),
      .rec_in    (head_rec),
      .rec_pop   (queue_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

FILE: bench/tb.sv
// Testbench: streams ISO 8601 text into the epoch converter and checks every result.
`timescale 1ns / 1ps
module tb;

   localparam int IDLE_PCT    = 22;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_LIMIT = 4000;
   localparam int TAIL_CYCLES = 16;
   localparam int PRINT_CAP   = 40;

   localparam logic [7:0] CH_ZERO  = "0";
   localparam logic [7:0] CH_NINE  = "9";
   localparam logic [7:0] CH_DASH  = "-";
   localparam logic [7:0] CH_PLUS  = "+";
   localparam logic [7:0] CH_COLON = ":";
   localparam logic [7:0] CH_T     = "T";
   localparam logic [7:0] CH_Z     = "Z";
   localparam logic [7:0] CH_DOT   = ".";

   localparam longint SECS_PER_DAY  = 86400;
   localparam longint SECS_PER_HOUR = 3600;
   localparam longint SECS_PER_MIN  = 60;

   typedef logic [7:0] char_q_type [$];

   typedef struct packed {
      logic [4:0]  pos;
      logic [13:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [19:0] second;
      logic        sec_closed;
      logic        fault;
      logic        off_found;
      logic        off_neg;
      logic        off_bad;
      logic [2:0]  off_step;
      logic [6:0]  off_hours;
      logic [6:0]  off_minutes;
   } parse_state_type;

   typedef struct packed {
      logic signed [38:0] epoch;
      logic               fault;
   } epoch_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   ite_req_if req_chan ();
   ite_rsp_if rsp_chan ();

   iso8601_timestamp_to_epoch_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   parse_state_type  parse          = '0;
   logic             convert_mirror = 1'b1;
   epoch_result_type expected_epochs [$];
   bit               gaps_on        = 1'b1;
   int               mismatches     = 0;
   int               results_checked = 0;
   int               chars_sent     = 0;
   int               strings_sent   = 0;
   int               cycle_count    = 0;

   task automatic note_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("mismatch at %0t: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // days from 1970-01-01 to the first of month m (1..12) of year y, proleptic Gregorian
   function automatic longint days_before_month(longint y, longint m);
      longint era, yoe, doy, doe;
      if (m <= 2) y = y - 1;
      era = (y >= 0 ? y : y - 399) / 400;
      yoe = y - era * 400;
      doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
   endfunction

   function automatic logic [38:0] epoch_now();
      longint yr, mon, secs, off;
      yr  = longint'(parse.year);
      mon = longint'(parse.month) - 1;
      // month overflow carries into the year; month 00 falls back to December
      if (mon < 0) begin
         yr  = yr - 1;
         mon = mon + 12;
      end else begin
         yr  = yr + mon / 12;
         mon = mon % 12;
      end
      secs = (days_before_month(yr, mon + 1) + longint'(parse.day) - 1) * SECS_PER_DAY
           + longint'(parse.hour) * SECS_PER_HOUR + longint'(parse.minute) * SECS_PER_MIN
           + longint'(parse.second);
      if (convert_mirror && parse.off_found) begin
         off  = longint'(parse.off_hours) * SECS_PER_HOUR
              + longint'(parse.off_minutes) * SECS_PER_MIN;
         secs = parse.off_neg ? secs + off : secs - off;
      end
      return secs[38:0];
   endfunction

   // folds one character into the parse; returns 1 with the result on the last one
   function automatic bit absorb_char(input logic [7:0] c, input bit last,
                                      output epoch_result_type res);
      logic [4:0] p;
      bit         dig;
      logic [3:0] d;
      bit         bad;
      p   = parse.pos;
      dig = (c >= CH_ZERO) && (c <= CH_NINE);
      d   = dig ? 4'(c - CH_ZERO) : 4'd0;
      res = '0;
      case (p)
         0, 1, 2, 3: begin
            parse.year = parse.year * 10 + d;
            if (!dig) parse.fault = 1'b1;
         end
         5, 6: begin
            parse.month = parse.month * 10 + d;
            if (!dig) parse.fault = 1'b1;
         end
         8, 9: begin
            parse.day = parse.day * 10 + d;
            if (!dig) parse.fault = 1'b1;
         end
         11, 12: begin
            parse.hour = parse.hour * 10 + d;
            if (!dig) parse.fault = 1'b1;
         end
         14, 15: begin
            parse.minute = parse.minute * 10 + d;
            if (!dig) parse.fault = 1'b1;
         end
         4, 7:   if (c != CH_DASH) parse.fault = 1'b1;
         10:     if (c != CH_T) parse.fault = 1'b1;
         13, 16: if (c != CH_COLON) parse.fault = 1'b1;
         default: ;
      endcase

      if (p >= 17 && p <= 22 && !parse.sec_closed) begin
         if (dig) parse.second = parse.second * 10 + d;
         else parse.sec_closed = 1'b1;
      end

      // offset: sign, two hour digits, one skipped character, two minute digits
      if (p >= 19) begin
         if (!parse.off_found) begin
            if (c == CH_PLUS || c == CH_DASH) begin
               parse.off_found = 1'b1;
               parse.off_neg   = (c == CH_DASH);
               parse.off_step  = 3'd1;
            end
         end else if (parse.off_step >= 3'd1 && parse.off_step <= 3'd5) begin
            if (parse.off_step <= 3'd2) begin
               parse.off_hours = parse.off_hours * 10 + d;
               if (!dig) parse.off_bad = 1'b1;
            end else if (parse.off_step >= 3'd4) begin
               parse.off_minutes = parse.off_minutes * 10 + d;
               if (!dig) parse.off_bad = 1'b1;
            end
            parse.off_step = parse.off_step + 3'd1;
         end
      end

      if (parse.pos != 5'd31) parse.pos = parse.pos + 5'd1;
      if (!last) return 1'b0;

      bad = parse.fault || (p < 5'd18)
         || (convert_mirror && parse.off_found && (parse.off_bad || parse.off_step != 3'd6));
      if (bad) begin
         res.epoch = '0;
         res.fault = 1'b1;
      end else begin
         res.epoch = epoch_now();
         res.fault = 1'b0;
      end
      parse = '0;
      return 1'b1;
   endfunction

   // result checking and prediction, both on accepted transfers
   always @(posedge clock) begin
      epoch_result_type want;
      epoch_result_type fresh;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_checked++;
            if (expected_epochs.size() == 0) begin
               note_mismatch("result with nothing outstanding",
                             longint'(rsp_chan.unix_secs), 0);
            end else begin
               want = expected_epochs.pop_front();
               if (rsp_chan.format_error !== want.fault)
                  note_mismatch("format_error", longint'(rsp_chan.format_error),
                                longint'(want.fault));
               if (rsp_chan.unix_secs !== want.epoch)
                  note_mismatch("unix_secs", longint'(rsp_chan.unix_secs),
                                longint'($signed(want.epoch)));
            end
         end
         if (csr_wr_en) convert_mirror = csr_wr_data;
         if (req_chan.valid && req_chan.ready) begin
            if (absorb_char(req_chan.char_code, req_chan.last_char, fresh))
               expected_epochs.push_back(fresh);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_epochs.size());
         $display("tb: errors");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
      end
   end

   task automatic send_char(input logic [7:0] code, input bit last);
      @(negedge clock);
      while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.char_code <= code;
      req_chan.last_char <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_bytes(input char_q_type t);
      for (int i = 0; i < t.size(); i++)
         send_char(t[i], i == t.size() - 1);
      strings_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], i == s.len() - 1);
      strings_sent++;
   endtask

   task automatic push_text(ref char_q_type t, input string s);
      for (int i = 0; i < s.len(); i++)
         t.push_back(s[i]);
   endtask

   task automatic push_field(ref char_q_type t, input int unsigned v, input int ndig);
      int unsigned div;
      div = 1;
      repeat (ndig - 1) div = div * 10;
      repeat (ndig) begin
         t.push_back(CH_ZERO + 8'((v / div) % 10));
         div = div / 10;
      end
   endtask

   // quiet the request side and let outstanding results drain
   task automatic settle();
      int n;
      @(negedge clock);
      req_chan.valid <= 1'b0;
      n = 0;
      while (expected_epochs.size() != 0 && n < DRAIN_LIMIT) begin
         @(negedge clock);
         n++;
      end
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic write_convert(input logic v);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic test_valid_stamps();
      send_text("1970-01-01T00:00:00Z");
      send_text("2024-02-29T23:59:60.123+05:30");
      send_text("1999-12-31T23:59:59-08:00");
   endtask

   task automatic test_extremes();
      send_text("9999-99-99T99:99:999999-99:99");
      send_text("0000-00-00T00:00:00+99:99");
   endtask

   task automatic test_lengths();
      send_text("7");
      send_text("2021-06-15T12:34:5");
      send_text("2021-06-15T12:34:56");
      // seconds with no digits count as zero
      send_text("2021-06-15T12:34:ab");
   endtask

   task automatic test_separators();
      send_text("2021/06-15T12:34:56");
      send_text("2021-06/15T12:34:56");
      send_text("2021-06-15 12:34:56");
      send_text("2021-06-15T12.34:56");
      send_text("2021-06-15T12:34.56");
   endtask

   task automatic test_field_digits();
      send_text("2O21-06-15T12:34:56");
      send_text("2021-06-1xT12:34:56");
   endtask

   task automatic test_offsets();
      send_text("2021-06-15T12:34:56+05:");
      send_text("2021-06-15T12:34:56+0a:30");
      send_text("2021-06-15T12:34:56-01:00+02:00");
      send_text("2021-06-15T12:34:56.5-0230");
      // sign before the offset window is ignored
      send_text("2021-06-15T12:34:+7+01:00");
   endtask

   task automatic test_odd_characters();
      char_q_type t;
      t = {};
      push_text(t, "2021-06-15T12:34:56");
      t.push_back(8'h00);
      t.push_back(8'hFF);
      t.push_back(8'h80);
      send_bytes(t);
      t = {};
      push_text(t, "20");
      t.push_back(8'h00);
      push_text(t, "1-06-15T12:34:56Z");
      send_bytes(t);
      // runs well past the saturating position
      send_text("2021-06-15T12:34:56.123456789012345678+01:00");
   endtask

   task automatic test_offset_disabled();
      write_convert(1'b0);
      send_text("2021-06-15T12:34:56+05:");
      send_text("2021-06-15T12:34:56-0x:3y");
      send_text("2000-03-01T00:00:00+14:00");
      write_convert(1'b1);
   endtask

   // mostly well-formed stamps with random content, some damaged, some pure noise
   task automatic make_random_text(ref char_q_type t);
      int kind, n, r;
      t = {};
      kind = $urandom_range(0, 99);
      if (kind >= 85) begin
         n = $urandom_range(1, 40);
         repeat (n) t.push_back(8'($urandom_range(0, 255)));
         return;
      end
      push_field(t, $urandom_range(0, 9999), 4);
      t.push_back(CH_DASH);
      push_field(t, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99)
                                                 : $urandom_range(1, 12), 2);
      t.push_back(CH_DASH);
      push_field(t, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99)
                                                 : $urandom_range(1, 28), 2);
      t.push_back(CH_T);
      push_field(t, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99)
                                                 : $urandom_range(0, 23), 2);
      t.push_back(CH_COLON);
      push_field(t, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99)
                                                 : $urandom_range(0, 59), 2);
      t.push_back(CH_COLON);
      r = $urandom_range(0, 9);
      n = (r == 0) ? 0 : (r == 1) ? 1 : (r <= 7) ? 2 : $urandom_range(3, 6);
      push_field(t, $urandom_range(0, 999999), n);
      if ($urandom_range(0, 99) < 30) begin
         t.push_back(CH_DOT);
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
         repeat (n) t.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      r = $urandom_range(0, 9);
      if (r == 2) begin
         t.push_back(CH_Z);
      end else if (r >= 3 && r <= 7) begin
         t.push_back($urandom_range(0, 1) ? CH_PLUS : CH_DASH);
         push_field(t, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99)
                                                    : $urandom_range(0, 14), 2);
         if ($urandom_range(0, 9) != 0) t.push_back(CH_COLON);
         push_field(t, $urandom_range(0, 59), 2);
      end else if (r == 8) begin
         t.push_back($urandom_range(0, 1) ? CH_PLUS : CH_DASH);
         n = $urandom_range(0, 4);
         repeat (n) t.push_back($urandom_range(0, 1) ? CH_ZERO + 8'($urandom_range(0, 9))
                                                      : 8'($urandom_range(32, 126)));
      end else if (r == 9) begin
         n = $urandom_range(1, 8);
         repeat (n) t.push_back(8'($urandom_range(32, 126)));
      end
      if (kind >= 70) begin
         if ($urandom_range(0, 1)) begin
            t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
         end else begin
            n = $urandom_range(1, t.size());
            while (t.size() > n) void'(t.pop_back());
         end
      end
   endtask

   task automatic test_random_traffic();
      char_q_type t;
      int phase_chars;
      for (int ph = 0; ph < 4; ph++) begin
         write_convert((ph % 2 == 0) ? 1'b1 : 1'b0);
         gaps_on = (ph != 2);
         phase_chars = 0;
         // the phase without idling runs longest
         while (phase_chars < ((ph == 2) ? 100 : 40)) begin
            make_random_text(t);
            send_bytes(t);
            phase_chars += t.size();
         end
      end
      settle();
      gaps_on = 1'b1;
   endtask

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = 1'b0;
      req_chan.valid     = 1'b0;
      req_chan.char_code = 8'h00;
      req_chan.last_char = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_valid_stamps();
      test_extremes();
      test_lengths();
      test_separators();
      test_field_digits();
      test_offsets();
      test_odd_characters();
      test_offset_disabled();
      test_random_traffic();

      settle();
      if (expected_epochs.size() != 0)
         note_mismatch("results never delivered", 0, longint'(expected_epochs.size()));

      $display("summary: %0d strings in %0d characters, %0d results checked, %0d mismatches",
               strings_sent, chars_sent, results_checked, mismatches);
      $display("summary: both offset settings, field extremes, bad formats and random noise");
      if (mismatches == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/ite_pkg.sv
rtl/ite_req_if.sv
rtl/ite_front.sv
rtl/ite_queue.sv
rtl/ite_back.sv
rtl/iso8601_timestamp_to_epoch_top.sv
bench/tb.sv
